[rtl/box_filter_line_blur_defines.svh]
`ifndef BOX_FILTER_LINE_BLUR_DEFINES_SVH
`define BOX_FILTER_LINE_BLUR_DEFINES_SVH

// same-cycle implication, checked on aclk outside reset
`define BFLB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked on aclk outside reset
`define BFLB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/bflb_pkg.sv]
`timescale 1ns / 1ps

package bflb_pkg;

    localparam int MAX_WINDOW  = 31;
    localparam int MAX_LINE    = 4096;
    localparam int LINE_W      = $clog2(MAX_LINE);
    localparam int HI_W        = LINE_W + 1;
    localparam int PIX_W       = 8;
    localparam int WIDTH_W     = 5;
    localparam int SUM_W       = 13;
    localparam int STORE_DEPTH = 32;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(3);
    localparam logic [WIDTH_W-1:0] WIDTH_CAP   = WIDTH_W'((MAX_WINDOW - 1) | 1);
    localparam logic [LINE_W-1:0]  LAST_POS    = LINE_W'(MAX_LINE - 1);

    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic [LINE_W-1:0] pos;
        logic              last;
    } item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_EMIT
    } back_state_t;

    function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] ww);
        logic [WIDTH_W-1:0] w;
        w = ww;
        if (!w[0]) begin
            w = w + WIDTH_W'(1);
        end
        if (w > WIDTH_CAP) begin
            w = WIDTH_CAP;
        end
        return w;
    endfunction

    // ceil(2^RECIP_SHIFT / w), exact quotient for every 13-bit sum
    function automatic logic [RECIP_W-1:0] recip(input logic [WIDTH_W-1:0] w);
        logic [RECIP_W-1:0] r;
        unique case (w)
            5'd1:    r = RECIP_W'(262144);
            5'd3:    r = RECIP_W'(87382);
            5'd5:    r = RECIP_W'(52429);
            5'd7:    r = RECIP_W'(37450);
            5'd9:    r = RECIP_W'(29128);
            5'd11:   r = RECIP_W'(23832);
            5'd13:   r = RECIP_W'(20165);
            5'd15:   r = RECIP_W'(17477);
            5'd17:   r = RECIP_W'(15421);
            5'd19:   r = RECIP_W'(13798);
            5'd21:   r = RECIP_W'(12484);
            5'd23:   r = RECIP_W'(11398);
            5'd25:   r = RECIP_W'(10486);
            5'd27:   r = RECIP_W'(9710);
            5'd29:   r = RECIP_W'(9040);
            5'd31:   r = RECIP_W'(8457);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[rtl/box_filter_line_blur.sv]
`timescale 1ns / 1ps
// Each pixel passes the two-entry queue, then the back-end sum and emit states, with the registered
// 32-entry window memory read between; emit registers the result, waits while the output holds one
// unaccepted, then pops the next pixel. A line-end pixel adds a sum/emit step per flushed result.
// Reset (aresetn, synchronous, active low): clears control state, window_width returns to 3;
// the window memory is not cleared and needs no clearing pass.

module box_filter_line_blur (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [bflb_pkg::WIDTH_W-1:0] cfg_wr_data,  // window_width
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bflb_pkg::PIX_W-1:0]   s_tdata,      // [7:0] pixel
    input  logic                         s_tlast,      // line_end
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bflb_pkg::PIX_W-1:0]   m_tdata,      // [7:0] average
    output logic                         m_tlast       // last_of_line
);
    import bflb_pkg::*;

    logic [WIDTH_W-1:0] width_reg, width_next;
    logic [WIDTH_W-1:0] width_eff;
    logic               fq_valid, fq_ready, bq_valid, bq_ready;
    item_t              fq_item, bq_item;

    assign width_next = cfg_wr_en ? cfg_wr_data : width_reg;
    assign width_eff  = eff_width(width_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WIDTH_RESET;
        end else begin
            width_reg <= width_next;
        end
    end

    bflb_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (cfg_wr_en),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_item   (fq_item)
    );

    bflb_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (bq_valid),
        .out_ready (bq_ready),
        .out_item  (bq_item)
    );

    bflb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .width_eff (width_eff),
        .q_valid   (bq_valid),
        .q_ready   (bq_ready),
        .q_item    (bq_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

[rtl/bflb_front.sv]
`timescale 1ns / 1ps

module bflb_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   clear,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [bflb_pkg::PIX_W-1:0] s_tdata,  // [7:0] pixel
    input  logic                   s_tlast,      // line_end
    output logic                   q_valid,
    input  logic                   q_ready,
    output bflb_pkg::item_t        q_item
);
    import bflb_pkg::*;

    logic [LINE_W-1:0] pos_reg, pos_next;
    logic              line_done;

    assign s_tready  = q_ready;
    assign q_valid   = s_tvalid;
    // close the line on line_end or when the line reaches its maximum length
    assign line_done = s_tlast || (pos_reg == LAST_POS);

    always_comb begin
        q_item.pixel = s_tdata;
        q_item.pos   = pos_reg;
        q_item.last  = line_done;
    end

    always_comb begin
        pos_next = pos_reg;
        if (clear) begin
            pos_next = '0;
        end else if (s_tvalid && q_ready) begin
            pos_next = line_done ? '0 : pos_reg + LINE_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

[rtl/bflb_fifo.sv]
`timescale 1ns / 1ps

module bflb_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  bflb_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output bflb_pkg::item_t out_item
);
    import bflb_pkg::*;

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[rtl/bflb_back.sv]
`timescale 1ns / 1ps
`include "box_filter_line_blur_defines.svh"

module bflb_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [bflb_pkg::WIDTH_W-1:0] width_eff,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  bflb_pkg::item_t              q_item,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bflb_pkg::PIX_W-1:0]   m_tdata,  // [7:0] average
    output logic                         m_tlast   // last_of_line
);
    import bflb_pkg::*;

    back_state_t        state_reg, state_next;
    logic [HI_W-1:0]    hi_reg, hi_next;
    logic [LINE_W-1:0]  n_reg, n_next;
    logic [PIX_W-1:0]   pix_reg, pix_next;
    logic               end_reg, end_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               m_valid_reg, m_valid_next;
    logic [PIX_W-1:0]   avg_reg;
    logic               last_reg;

    logic [PIX_W-1:0]   store_mem [STORE_DEPTH];
    logic [PIX_W-1:0]   rd_reg;
    logic [STORE_AW-1:0] rd_addr;
    logic [HI_W-1:0]    lo_pos;

    logic [WIDTH_W-1:0] p, p_plus1;
    logic [HI_W-1:0]    end_pos;
    logic               more, emit_here, out_free, step_ok, pop, out_load;
    logic [SUM_W-1:0]   first_sum, slide_sum;
    logic [PROD_W-1:0]  prod;

    assign p         = width_eff >> 1;
    assign p_plus1   = p + WIDTH_W'(1);
    assign end_pos   = HI_W'(n_reg) + HI_W'(p);
    assign more      = end_reg && (hi_reg < end_pos);
    assign emit_here = (hi_reg >= HI_W'(p));
    assign out_free  = !m_valid_reg || m_tready;
    assign step_ok   = !emit_here || out_free;
    assign q_ready   = pop;

    assign first_sum = SUM_W'(p_plus1) * SUM_W'(pix_reg);
    assign slide_sum = sum_reg + SUM_W'(pix_reg)
                     - ((hi_reg > HI_W'(p)) ? SUM_W'(rd_reg) : SUM_W'(0));
    assign prod      = PROD_W'(sum_reg) * PROD_W'(recip(width_eff));

    // oldest pixel leaving the window for the step at hi_next
    assign lo_pos  = (hi_next >= HI_W'(width_eff)) ? hi_next - HI_W'(width_eff) : '0;
    assign rd_addr = lo_pos[STORE_AW-1:0];

    always_comb begin
        state_next = state_reg;
        hi_next    = hi_reg;
        n_next     = n_reg;
        pix_next   = pix_reg;
        end_next   = end_reg;
        sum_next   = sum_reg;
        pop        = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    pop        = 1'b1;
                    hi_next    = HI_W'(q_item.pos);
                    n_next     = q_item.pos;
                    pix_next   = q_item.pixel;
                    end_next   = q_item.last;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                sum_next   = (hi_reg == '0) ? first_sum : slide_sum;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (step_ok) begin
                    out_load = emit_here;
                    if (more) begin
                        hi_next    = hi_reg + HI_W'(1);
                        state_next = ST_SUM;
                    end else if (q_valid) begin
                        pop        = 1'b1;
                        hi_next    = HI_W'(q_item.pos);
                        n_next     = q_item.pos;
                        pix_next   = q_item.pixel;
                        end_next   = q_item.last;
                        state_next = ST_SUM;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hi_reg  <= hi_next;
        n_reg   <= n_next;
        pix_reg <= pix_next;
        end_reg <= end_next;
        sum_reg <= sum_next;
        if (out_load) begin
            avg_reg  <= prod[RECIP_SHIFT +: PIX_W];
            last_reg <= end_reg && (hi_reg == end_pos);
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            store_mem[q_item.pos[STORE_AW-1:0]] <= q_item.pixel;
        end
        rd_reg <= store_mem[rd_addr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = avg_reg;
    assign m_tlast  = last_reg;

    `BFLB_ASSERT_NOW(a_hi_in_range, state_reg != ST_IDLE, hi_reg <= end_pos)
    `BFLB_ASSERT_NEXT(a_pop_loads_pos, pop, (state_reg == ST_SUM) && (hi_reg == $past(q_item.pos)))
    `BFLB_ASSERT_NEXT(a_hold_result, m_valid_reg && !m_tready, m_valid_reg && $stable(avg_reg))

endmodule

[tb/tb_box_filter_line_blur.sv]
`timescale 1ns / 1ps

module tb_box_filter_line_blur;

    localparam int STORE_DEPTH  = 32;
    localparam int SUM_MASK     = (1 << bflb_pkg::SUM_W) - 1;
    localparam int WIDTH_CAP    = (bflb_pkg::MAX_WINDOW - 1) | 1;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 152;
    localparam int N_ROWS       = 24;

    typedef struct packed {
        logic [bflb_pkg::PIX_W-1:0] average;
        logic                       last_of_line;
    } blur_out_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PIX,
        ROW_TYPED
    } row_kind_t;

    typedef struct packed {
        row_kind_t                    kind;
        logic [bflb_pkg::WIDTH_W-1:0] width;
        logic [bflb_pkg::PIX_W-1:0]   pixel;
        logic                         line_end;
        logic [bflb_pkg::PIX_W-1:0]   t_avg;
        logic                         t_last;
    } step_row_t;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_PATTERN
    } rdy_mode_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_wr_en;
    logic [bflb_pkg::WIDTH_W-1:0] cfg_wr_data;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [bflb_pkg::PIX_W-1:0]   s_tdata;
    logic                         s_tlast;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [bflb_pkg::PIX_W-1:0]   m_tdata;
    logic                         m_tlast;

    box_filter_line_blur DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    logic [bflb_pkg::PIX_W-1:0] line_px [0:STORE_DEPTH-1];
    int unsigned                run_sum;
    int unsigned                px_count;
    int unsigned                width_reg;
    blur_out_t                  expected_avgs [$];
    int                         errors;
    int                         burst_left;

    rdy_mode_t                  ready_mode;
    int                         ready_left;
    int unsigned                ready_phase;

    step_row_t dir_rows [0:N_ROWS-1] = '{
        '{ROW_TYPED, 5'd0,  8'd255, 1'b1, 8'd255, 1'b1},
        '{ROW_TYPED, 5'd0,  8'd0,   1'b1, 8'd0,   1'b1},
        '{ROW_PIX,   5'd0,  8'd10,  1'b0, 8'd0,   1'b0},
        '{ROW_PIX,   5'd0,  8'd200, 1'b1, 8'd0,   1'b0},
        '{ROW_CFG,   5'd0,  8'd0,   1'b0, 8'd0,   1'b0},
        '{ROW_TYPED, 5'd0,  8'd0,   1'b0, 8'd0,   1'b0},
        '{ROW_TYPED, 5'd0,  8'd255, 1'b0, 8'd255, 1'b0},
        '{ROW_TYPED, 5'd0,  8'd128, 1'b1, 8'd128, 1'b1},
        '{ROW_CFG,   5'd31, 8'd0,   1'b0, 8'd0,   1'b0},
        '{ROW_PIX,   5'd0,  8'd255, 1'b0, 8'd0,   1'b0},
        '{ROW_PIX,   5'd0,  8'd0,   1'b0, 8'd0,   1'b0},
        '{ROW_PIX,   5'd0,  8'd255, 1'b1, 8'd0,   1'b0},
        '{ROW_CFG,   5'd30, 8'd0,   1'b0, 8'd0,   1'b0},
        '{ROW_TYPED, 5'd0,  8'd255, 1'b1, 8'd255, 1'b1},
        '{ROW_CFG,   5'd2,  8'd0,   1'b0, 8'd0,   1'b0},
        '{ROW_PIX,   5'd0,  8'd100, 1'b0, 8'd0,   1'b0},
        '{ROW_PIX,   5'd0,  8'd200, 1'b0, 8'd0,   1'b0},
        '{ROW_PIX,   5'd0,  8'd50,  1'b0, 8'd0,   1'b0},
        '{ROW_CFG,   5'd5,  8'd0,   1'b0, 8'd0,   1'b0},
        '{ROW_PIX,   5'd0,  8'd7,   1'b0, 8'd0,   1'b0},
        '{ROW_PIX,   5'd0,  8'd8,   1'b0, 8'd0,   1'b0},
        '{ROW_PIX,   5'd0,  8'd9,   1'b0, 8'd0,   1'b0},
        '{ROW_PIX,   5'd0,  8'd255, 1'b1, 8'd0,   1'b0},
        '{ROW_CFG,   5'd3,  8'd0,   1'b0, 8'd0,   1'b0}
    };

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic void slide_window(input int unsigned hi, input int unsigned newest,
                                         input int unsigned half);
        int unsigned s;
        int unsigned lo;
        s = run_sum + line_px[newest % STORE_DEPTH];
        if (hi > half) begin
            lo = (hi >= 2 * half + 1) ? hi - 2 * half - 1 : 0;
            s = s - line_px[lo % STORE_DEPTH];
        end
        run_sum = s & SUM_MASK;
    endfunction

    function automatic void push_avg(input int unsigned w, input logic last);
        blur_out_t r;
        r.average      = bflb_pkg::PIX_W'(run_sum / w);
        r.last_of_line = last;
        expected_avgs.push_back(r);
    endfunction

    function automatic void blur_pixel(input logic [bflb_pkg::PIX_W-1:0] pix, input logic eol);
        int unsigned w;
        int unsigned half;
        int unsigned n;
        int unsigned hi;
        bit          line_done;
        w = width_reg;
        if (w % 2 == 0) w = w + 1;
        if (w > WIDTH_CAP) w = WIDTH_CAP;
        half = w / 2;
        n = px_count;
        line_done = eol || (n + 1 >= bflb_pkg::MAX_LINE);
        line_px[n % STORE_DEPTH] = pix;
        if (n == 0) begin
            run_sum = ((half + 1) * pix) & SUM_MASK;
        end else begin
            slide_window(n, n, half);
        end
        if (n >= half) push_avg(w, line_done && half == 0);
        if (line_done) begin
            for (hi = n + 1; hi <= n + half; hi++) begin
                slide_window(hi, n, half);
                if (hi >= half) push_avg(w, hi == n + half);
            end
            run_sum  = 0;
            px_count = 0;
        end else begin
            px_count = (n + 1) & 12'hFFF;
        end
    endfunction

    task automatic send_pixel(input logic [bflb_pkg::PIX_W-1:0] pix, input logic eol,
                              input bit typed, input logic [bflb_pkg::PIX_W-1:0] t_avg,
                              input logic t_last);
        int        mark;
        blur_out_t r;
        if (burst_left <= 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 9)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tlast  <= eol;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        mark = expected_avgs.size();
        blur_pixel(pix, eol);
        if (typed) begin
            while (expected_avgs.size() > mark) void'(expected_avgs.pop_back());
            r.average      = t_avg;
            r.last_of_line = t_last;
            expected_avgs.push_back(r);
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_avgs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_width(input logic [bflb_pkg::WIDTH_W-1:0] value);
        wait_drained();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        width_reg = value;
        run_sum   = 0;
        px_count  = 0;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [bflb_pkg::PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return bflb_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    always @(negedge aclk) begin
        if (ready_left == 0) begin
            ready_mode <= rdy_mode_t'($urandom_range(0, 3));
            ready_left <= $urandom_range(20, 200);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            RDY_ALWAYS: m_tready <= 1'b1;
            RDY_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
            RDY_SPARSE: m_tready <= ($urandom_range(0, 4) == 0);
            default:    m_tready <= (ready_phase[1:0] != 2'b11);
        endcase
        ready_phase <= ready_phase + 1;
    end

    always @(posedge aclk) begin
        blur_out_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_avgs.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got average %0d last %0b",
                         $time, m_tdata, m_tlast);
                errors++;
            end else begin
                e = expected_avgs.pop_front();
                if (m_tdata !== e.average) begin
                    $display("%0t: average mismatch, expected %0d, got %0d",
                             $time, e.average, m_tdata);
                    errors++;
                end
                if (m_tlast !== e.last_of_line) begin
                    $display("%0t: last_of_line mismatch, expected %0b, got %0b",
                             $time, e.last_of_line, m_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int          row;
        int          random_sent;
        int          phase;
        int          n_lines;
        int          ln;
        int          line_len;
        int          i;
        bit          cut;
        logic        eol;
        logic [bflb_pkg::WIDTH_W-1:0] new_width;

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        ready_mode  = RDY_ALWAYS;
        ready_left  = 0;
        ready_phase = 0;
        errors      = 0;
        burst_left  = 0;
        width_reg   = bflb_pkg::WIDTH_RESET;
        run_sum     = 0;
        px_count    = 0;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (row = 0; row < N_ROWS; row++) begin
            if (dir_rows[row].kind == ROW_CFG) begin
                write_width(dir_rows[row].width);
            end else begin
                send_pixel(dir_rows[row].pixel, dir_rows[row].line_end,
                           dir_rows[row].kind == ROW_TYPED,
                           dir_rows[row].t_avg, dir_rows[row].t_last);
            end
        end

        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       new_width = bflb_pkg::WIDTH_W'($urandom_range(0, 1));
                1:       new_width = bflb_pkg::WIDTH_W'($urandom_range(30, 31));
                default: new_width = bflb_pkg::WIDTH_W'($urandom_range(0, 31));
            endcase
            if (phase == 0) new_width = 5'd31;
            write_width(new_width);
            n_lines = $urandom_range(1, 4);
            for (ln = 0; ln < n_lines && random_sent < RANDOM_ITEMS; ln++) begin
                line_len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 40)
                                                       : $urandom_range(1, 12);
                if (phase == 0 && ln == 0) line_len = 20;
                // leave the line open so the next width write abandons it
                cut = (ln == n_lines - 1) && ($urandom_range(0, 4) == 0);
                for (i = 0; i < line_len && random_sent < RANDOM_ITEMS; i++) begin
                    if ($urandom_range(0, 29) == 0) wait_drained();
                    eol = ((i == line_len - 1) && !cut) || ($urandom_range(0, 31) == 0);
                    send_pixel(rand_pixel(), eol, 1'b0, '0, 1'b0);
                    random_sent++;
                end
            end
            phase++;
        end

        wait_drained();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
